// ===== hw/rtl/tgr_pkg.sv =====
package tgr_pkg;

   // function codes of an input transaction
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_MOVE   = 2'd1;
   localparam logic [1:0] FUNC_RENDER = 2'd2;

   // configuration register indexes
   localparam logic CSR_DRAW_COLOR  = 1'b0;
   localparam logic CSR_PIXEL_SCALE = 1'b1;

   // character set
   localparam logic [7:0] FIRST_CODE   = 8'd32;
   localparam logic [7:0] LAST_CODE    = 8'd126;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam int         GLYPH_COUNT  = 95;
   localparam int         BITMAP_BITS  = 15;

   // clamp an 18-bit signed sum to the 16-bit coordinate range
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // cursor plus a small unsigned offset, saturated
   function automatic logic signed [15:0] add_sat(input logic signed [15:0] base,
                                                  input logic [6:0] ofs);
      logic signed [17:0] sum;
      sum = $signed({{2{base[15]}}, base}) + $signed({11'd0, ofs});
      return sat16(sum);
   endfunction

endpackage

// ===== hw/rtl/text_glyph_rasterizer.sv =====
// text_glyph_rasterizer: bitmap font character generator
//
// req channel (req_valid / req_stall) carries one transaction per command:
//   load  stores a 16-bit glyph word for codes 32..126 in the glyph memory
//   move  sets cursor and line start column
//   render draws one character byte at the cursor and advances it
// rsp channel (rsp_valid / rsp_stall) carries one pixel per transaction with
// the current draw color; last_pixel marks the final pixel of a character
// csr port writes draw_color (index 0) and pixel_scale (index 1) at any
// cycle with csr_write_enable high
// load, move, newline, space and unprintable codes finish in the idle state
// a printable character reads the glyph memory and latches the glyph in the
// read state, then walks each bitmap position up to its last set dot and
// sends scale*scale sub-pixels for every set dot; the pace is set by the
// single pixel output register, at most one pixel per cycle while rsp_stall
// is low
// a pending pixel waits in the output register while rsp_stall is high and
// the walk holds at its set dot; the next command is taken even while it waits
// reset clears cursor, line start, draw color and both channels, sets
// pixel_scale to 1; glyph memory contents stay undefined until loaded
module text_glyph_rasterizer #(
   parameter int GLYPH_WIDTH  = 3,
   parameter int GLYPH_HEIGHT = 5,
   parameter int CHAR_ADVANCE = 4,
   parameter int MAX_SCALE    = 2
) (
   input  logic               clock,
   input  logic               reset,
   // command channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_char_code,
   input  logic [15:0]        req_glyph_word,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   // pixel channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pixel_x,
   output logic signed [15:0] rsp_pixel_y,
   output logic [31:0]        rsp_pixel_color,
   output logic               rsp_last_pixel,
   // configuration writes
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);

   // bitmap positions actually drawn
   localparam int BITS = (GLYPH_WIDTH * GLYPH_HEIGHT < tgr_pkg::BITMAP_BITS) ?
                         GLYPH_WIDTH * GLYPH_HEIGHT : tgr_pkg::BITMAP_BITS;
   localparam logic [14:0] BIT_MASK = 15'((32'd1 << BITS) - 32'd1);
   localparam int GX_W = $clog2(GLYPH_WIDTH + 1);
   localparam int GY_W = $clog2(GLYPH_HEIGHT + 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_WALK = 2'd2;

   // configuration
   logic [31:0]        draw_color_ff;
   logic [1:0]         pixel_scale_ff;
   logic [1:0]         scale;

   // glyph memory, one synchronous read port and one write port
   logic [15:0]        glyph_mem [tgr_pkg::GLYPH_COUNT];
   logic [15:0]        mem_rdata_ff;
   logic               mem_we;
   logic               mem_re;
   logic [6:0]         mem_addr;

   // sequencer and cursor state
   logic [1:0]         state_ff, state_in;
   logic signed [15:0] cur_col_ff, cur_col_in;
   logic signed [15:0] cur_row_ff, cur_row_in;
   logic signed [15:0] line_col_ff, line_col_in;
   logic [14:0]        glyph_ff, glyph_in;
   logic               drop_ff, drop_in;
   logic [3:0]         bit_ff, bit_in;
   logic [GX_W-1:0]    gx_ff, gx_in;
   logic [GY_W-1:0]    gy_ff, gy_in;
   logic [1:0]         sx_ff, sx_in;
   logic [1:0]         sy_ff, sy_in;

   // pixel output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_x_ff, rsp_x_in;
   logic signed [15:0] rsp_y_ff, rsp_y_in;
   logic [31:0]        rsp_color_ff, rsp_color_in;
   logic               rsp_last_ff, rsp_last_in;

   // walk helpers
   logic               req_take;
   logic               out_free;
   logic               bit_set;
   logic               more_dots;
   logic               sx_end;
   logic               sy_end;
   logic               last_sub;
   logic [6:0]         ofs_x;
   logic [6:0]         ofs_y;
   logic [6:0]         advance;
   logic [14:0]        read_bits;

   // effective scale: zero acts as one, clamp to the maximum
   always_comb begin
      if (pixel_scale_ff == 2'd0) begin
         scale = 2'd1;
      end else if (32'(pixel_scale_ff) > MAX_SCALE) begin
         scale = 2'(MAX_SCALE);
      end else begin
         scale = pixel_scale_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign bit_set   = glyph_ff[bit_ff];
   assign more_dots = ((glyph_ff >> bit_ff) >> 1) != 15'd0;
   assign sx_end    = (sx_ff == scale - 2'd1);
   assign sy_end    = (sy_ff == scale - 2'd1);
   assign last_sub  = sx_end && sy_end;

   // pixel offsets inside the character cell
   assign ofs_x   = 7'(gx_ff) * 7'(scale) + 7'(sx_ff);
   assign ofs_y   = 7'(gy_ff) * 7'(scale) + 7'(sy_ff) + (drop_ff ? 7'(scale) : 7'd0);
   assign advance = 7'(CHAR_ADVANCE) * 7'(scale);

   assign read_bits = mem_rdata_ff[14:0] & BIT_MASK;

   // memory port control
   assign mem_addr = 7'(req_char_code - tgr_pkg::FIRST_CODE);
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      if (req_take && req_func == tgr_pkg::FUNC_LOAD &&
          (req_char_code inside {[tgr_pkg::FIRST_CODE:tgr_pkg::LAST_CODE]})) begin
         mem_we = 1'b1;
      end
      if (req_take && req_func == tgr_pkg::FUNC_RENDER &&
          (req_char_code inside {[tgr_pkg::FIRST_CODE + 8'd1:tgr_pkg::LAST_CODE]})) begin
         mem_re = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_mem[mem_addr] <= req_glyph_word;
      end
      if (mem_re) begin
         mem_rdata_ff <= glyph_mem[mem_addr];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      line_col_in  = line_col_ff;
      glyph_in     = glyph_ff;
      drop_in      = drop_ff;
      bit_in       = bit_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_func)
                  tgr_pkg::FUNC_MOVE: begin
                     cur_col_in  = req_pos_x;
                     line_col_in = req_pos_x;
                     cur_row_in  = req_pos_y;
                  end
                  tgr_pkg::FUNC_RENDER: begin
                     if (req_char_code == tgr_pkg::NEWLINE_CODE) begin
                        cur_row_in = tgr_pkg::add_sat(cur_row_ff,
                                        7'(GLYPH_HEIGHT + 2) * 7'(scale));
                        cur_col_in = line_col_ff;
                     end else if (mem_re) begin
                        // printable: fetch the glyph and start the walk
                        state_in = ST_READ;
                        bit_in   = 4'd0;
                        gx_in    = '0;
                        gy_in    = '0;
                        sx_in    = 2'd0;
                        sy_in    = 2'd0;
                     end else begin
                        cur_col_in = tgr_pkg::add_sat(cur_col_ff, advance);
                     end
                  end
                  default: begin
                     // load goes straight to memory, unknown func is dropped
                  end
               endcase
            end
         end
         ST_READ: begin
            glyph_in = read_bits;
            drop_in  = mem_rdata_ff[15];
            if (read_bits == 15'd0) begin
               // empty glyph: no pixels
               cur_col_in = tgr_pkg::add_sat(cur_col_ff, advance);
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (bit_set && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = tgr_pkg::add_sat(cur_col_ff, ofs_x);
               rsp_y_in     = tgr_pkg::add_sat(cur_row_ff, ofs_y);
               rsp_color_in = draw_color_ff;
               rsp_last_in  = last_sub && !more_dots;
            end
            if (bit_set && out_free && last_sub && !more_dots) begin
               cur_col_in = tgr_pkg::add_sat(cur_col_ff, advance);
               state_in   = ST_IDLE;
            end else if (bit_set && out_free && !sx_end) begin
               sx_in = sx_ff + 2'd1;
            end else if (bit_set && out_free && !sy_end) begin
               sx_in = 2'd0;
               sy_in = sy_ff + 2'd1;
            end else if (!bit_set || out_free) begin
               // move on to the next bitmap position
               sx_in  = 2'd0;
               sy_in  = 2'd0;
               bit_in = bit_ff + 4'd1;
               if (32'(gx_ff) == GLYPH_WIDTH - 1) begin
                  gx_in = '0;
                  gy_in = gy_ff + GY_W'(1);
               end else begin
                  gx_in = gx_ff + GX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         line_col_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         draw_color_ff  <= '0;
         pixel_scale_ff <= 2'd1;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         line_col_ff  <= line_col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               tgr_pkg::CSR_DRAW_COLOR:  draw_color_ff  <= csr_write_data;
               tgr_pkg::CSR_PIXEL_SCALE: pixel_scale_ff <= csr_write_data[1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // walk and payload registers
   always_ff @(posedge clock) begin
      glyph_ff     <= glyph_in;
      drop_ff      <= drop_in;
      bit_ff       <= bit_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   // the walk never runs past the drawable bitmap
   a_bit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> 32'(bit_ff) < BITS)
      else $error("glyph walk past last bitmap position");

   // a set dot always lies at or ahead of the walk position
   a_dot_ahead: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (glyph_ff >> bit_ff) != 15'd0)
      else $error("glyph walk with no set dot left");

   // sub-pixel counters stay below the scale
   a_sub_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (sx_ff < scale && sy_ff < scale))
      else $error("sub-pixel counter out of range");

   // the final pixel of a character returns the sequencer to idle
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && rsp_valid_in && !(rsp_valid_ff && rsp_stall) &&
       rsp_last_in) |=> state_ff == ST_IDLE)
      else $error("walk continued after last pixel");

endmodule

// ===== tb/sv/tb_text_glyph_rasterizer.sv =====
module tb_text_glyph_rasterizer;
   timeunit 1ns;
   timeprecision 1ps;

   // font geometry, matches the block's default parameters
   localparam int GLYPH_W   = 3;
   localparam int GLYPH_H   = 5;
   localparam int ADVANCE   = 4;
   localparam int SCALE_MAX = 2;

   // function code the block ignores
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // cycles to let an empty glyph walk finish before touching registers
   localparam int SETTLE_CYCLES = 64;
   // worst case: 60 pixels per character, each behind a random sink hold-off
   localparam int CYCLE_LIMIT   = 2000000;
   // counted random transactions per register setting
   localparam int PHASE_ITEMS   = 60;

   // one expected pixel
   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [31:0]        color;
      logic               last;
   } pixel_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_func = tgr_pkg::FUNC_LOAD;
   logic [7:0]         req_char_code = 8'd0;
   logic [15:0]        req_glyph_word = 16'd0;
   logic signed [15:0] req_pos_x = 16'sd0;
   logic signed [15:0] req_pos_y = 16'sd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_pixel_x;
   logic signed [15:0] rsp_pixel_y;
   logic [31:0]        rsp_pixel_color;
   logic               rsp_last_pixel;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = tgr_pkg::CSR_DRAW_COLOR;
   logic [31:0]        csr_write_data = 32'd0;

   // predictor state
   logic [15:0] font_words [0:tgr_pkg::GLYPH_COUNT-1];
   logic        font_written [0:tgr_pkg::GLYPH_COUNT-1];
   logic [7:0]  drawable_codes [$];
   int          pen_col;
   int          pen_row;
   int          margin_col;
   logic [31:0] color_setting;
   logic [1:0]  scale_setting;

   pixel_type expected_pixels [$];
   int        mismatches;
   int        cycle_count;
   int        send_quiet;
   int        recv_quiet;

   text_glyph_rasterizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_char_code    (req_char_code),
      .req_glyph_word   (req_glyph_word),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_pixel   (rsp_last_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL text_glyph_rasterizer");
         $finish;
      end
   end

   function automatic int clamp_coord(input int v);
      if (v > 32767) begin
         return 32767;
      end
      if (v < -32768) begin
         return -32768;
      end
      return v;
   endfunction

   // per-transaction wait, with occasional runs of back-to-back traffic
   task automatic pick_wait(inout int quiet, output int cycles);
      if (quiet > 0) begin
         quiet--;
         cycles = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         quiet  = $urandom_range(4, 24);
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, 12);
      end
   endtask

   // update the font/cursor state for one accepted transaction and queue
   // the pixels it should produce
   task automatic compute_pixels(input logic [1:0] func, input logic [7:0] code,
                                 input logic [15:0] word,
                                 input logic signed [15:0] x,
                                 input logic signed [15:0] y);
      int          s;
      int          drop;
      int          total;
      int          k;
      logic [15:0] glyph;
      pixel_type   px;
      // out-of-range scale settings clip to 1..max
      if (scale_setting == 2'd0) begin
         s = 1;
      end else if (scale_setting > SCALE_MAX) begin
         s = SCALE_MAX;
      end else begin
         s = int'(scale_setting);
      end
      case (func)
         tgr_pkg::FUNC_LOAD: begin
            if (code inside {[tgr_pkg::FIRST_CODE:tgr_pkg::LAST_CODE]}) begin
               font_words[code - tgr_pkg::FIRST_CODE] = word;
               // space never draws, so only codes above it are renderable
               if (code > tgr_pkg::FIRST_CODE &&
                   !font_written[code - tgr_pkg::FIRST_CODE]) begin
                  font_written[code - tgr_pkg::FIRST_CODE] = 1'b1;
                  drawable_codes.push_back(code);
               end
            end
         end
         tgr_pkg::FUNC_MOVE: begin
            pen_col    = int'(x);
            margin_col = int'(x);
            pen_row    = int'(y);
         end
         tgr_pkg::FUNC_RENDER: begin
            if (code == tgr_pkg::NEWLINE_CODE) begin
               pen_row = clamp_coord(pen_row + (GLYPH_H + 2) * s);
               pen_col = margin_col;
            end else begin
               if (code inside {[tgr_pkg::FIRST_CODE + 8'd1:tgr_pkg::LAST_CODE]}) begin
                  glyph = font_words[code - tgr_pkg::FIRST_CODE];
                  drop  = glyph[15] ? s : 0;
                  total = $countones(glyph[14:0]) * s * s;
                  k     = 0;
                  for (int b = 0; b < tgr_pkg::BITMAP_BITS && b < GLYPH_W * GLYPH_H;
                       b++) begin
                     if (glyph[b]) begin
                        for (int sy = 0; sy < s; sy++) begin
                           for (int sx = 0; sx < s; sx++) begin
                              px.x = 16'(clamp_coord(pen_col + (b % GLYPH_W) * s + sx));
                              px.y = 16'(clamp_coord(pen_row + (b / GLYPH_W) * s + sy +
                                                     drop));
                              px.color = color_setting;
                              px.last  = (k == total - 1);
                              expected_pixels.push_back(px);
                              k++;
                           end
                        end
                     end
                  end
               end
               pen_col = clamp_coord(pen_col + ADVANCE * s);
            end
         end
         default: begin
            // unused function code, nothing happens
         end
      endcase
   endtask

   // one request transaction: optional gap, then hold until accepted
   task automatic send_command(input logic [1:0] func, input logic [7:0] code,
                               input logic [15:0] word,
                               input logic signed [15:0] x,
                               input logic signed [15:0] y);
      int gap;
      pick_wait(send_quiet, gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_func       <= func;
      req_char_code  <= code;
      req_glyph_word <= word;
      req_pos_x      <= x;
      req_pos_y      <= y;
      do begin
         @(posedge clock);
      end while (req_stall);
      compute_pixels(func, code, word, x, y);
   endtask

   task automatic render_char(input logic [7:0] code);
      send_command(tgr_pkg::FUNC_RENDER, code, 16'($urandom), 16'($urandom),
                   16'($urandom));
   endtask

   task automatic move_pen(input logic signed [15:0] x, input logic signed [15:0] y);
      send_command(tgr_pkg::FUNC_MOVE, 8'($urandom), 16'($urandom), x, y);
   endtask

   task automatic load_glyph(input logic [7:0] code, input logic [15:0] word);
      send_command(tgr_pkg::FUNC_LOAD, code, word, 16'($urandom), 16'($urandom));
   endtask

   // stop sending until every queued pixel came back, then optionally let
   // a trailing glyph walk with no pixels run out
   task automatic wait_for_pixels(input int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // both registers, only called while the block is idle
   task automatic write_settings(input logic [31:0] color, input logic [1:0] scale);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= tgr_pkg::CSR_DRAW_COLOR;
      csr_write_data   <= color;
      @(posedge clock);
      color_setting = color;
      @(negedge clock);
      csr_index      <= tgr_pkg::CSR_PIXEL_SCALE;
      csr_write_data <= {30'd0, scale};
      @(posedge clock);
      scale_setting = scale;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [15:0] random_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'(32767 - int'($urandom_range(0, 40)));
         2: return 16'(-32768 + int'($urandom_range(0, 40)));
         default: return 16'(int'($urandom_range(0, 400)) - 100);
      endcase
   endfunction

   // pixel checker: every accepted pixel against the oldest expectation
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel at (%0d, %0d)", rsp_pixel_x, rsp_pixel_y);
            mismatches++;
         end else begin
            e = expected_pixels.pop_front();
            if (rsp_pixel_x !== e.x) begin
               $error("pixel_x: expected %0d, got %0d", e.x, rsp_pixel_x);
               mismatches++;
            end
            if (rsp_pixel_y !== e.y) begin
               $error("pixel_y: expected %0d, got %0d", e.y, rsp_pixel_y);
               mismatches++;
            end
            if (rsp_pixel_color !== e.color) begin
               $error("pixel_color: expected %h, got %h", e.color, rsp_pixel_color);
               mismatches++;
            end
            if (rsp_last_pixel !== e.last) begin
               $error("last_pixel: expected %0d, got %0d", e.last, rsp_last_pixel);
               mismatches++;
            end
         end
      end
   end

   // pixel sink: random hold-off before each pixel transaction
   initial begin
      int n;
      forever begin
         pick_wait(recv_quiet, n);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do begin
            @(posedge clock);
         end while (rsp_valid !== 1'b1);
      end
   end

   // glyph loads at the extremes, plus ignored traffic
   task automatic test_glyph_loads();
      load_glyph(8'd33, 16'h7FFF);      // every dot
      load_glyph(8'd126, 16'hFFFF);     // every dot, descender
      load_glyph(8'd34, 16'h0000);      // empty glyph
      load_glyph(8'd35, 16'h8001);      // single dot, descender
      load_glyph(8'd36, 16'h4000);      // bottom-right dot only
      load_glyph(tgr_pkg::FIRST_CODE, 16'h5555); // space keeps no pixels
      load_glyph(8'd31, 16'hFFFF);      // below the character set
      load_glyph(8'd127, 16'hFFFF);     // above the character set
      load_glyph(8'd255, 16'hAAAA);
      send_command(FUNC_UNUSED, 8'd33, 16'hFFFF, 16'sh7FFF, 16'sh7FFF);
   endtask

   // every render kind at reset settings
   task automatic test_render_basics();
      move_pen(16'sd5, -16'sd3);
      render_char(8'd33);
      render_char(8'd34);
      render_char(8'd35);
      render_char(tgr_pkg::FIRST_CODE);
      render_char(8'd0);
      render_char(8'd200);
      render_char(tgr_pkg::NEWLINE_CODE);
      render_char(8'd126);
      render_char(8'd36);
   endtask

   // clamping of pixels, cursor advance and newline at both ends
   task automatic test_coordinate_saturation();
      wait_for_pixels(SETTLE_CYCLES);
      write_settings(32'hFFFF_FFFF, 2'd3);   // scale above max clips
      move_pen(16'sh7FFF, 16'sh7FFF);
      render_char(8'd126);
      render_char(tgr_pkg::NEWLINE_CODE);
      move_pen(16'sh8000, 16'sh8000);
      render_char(8'd33);
      move_pen(16'sd32764, -16'sd2);
      render_char(8'd33);
      render_char(8'd33);
   endtask

   // random text under several register settings
   task automatic test_random_text();
      logic [1:0]  scales [6];
      logic [31:0] colors [6];
      int          counted;
      int          r;
      int          c;
      scales = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd2};
      colors = '{32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0000_0001, $urandom};
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_pixels(SETTLE_CYCLES);
         write_settings(colors[phase], scales[phase]);
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            // hold the sender until the pipe is empty now and then
            if (counted == PHASE_ITEMS / 2 || $urandom_range(0, 49) == 0) begin
               wait_for_pixels(0);
            end
            r = $urandom_range(0, 99);
            if (r < 55) begin
               render_char(drawable_codes[$urandom_range(0, drawable_codes.size() - 1)]);
               counted++;
            end else if (r < 63) begin
               render_char(tgr_pkg::NEWLINE_CODE);
               counted++;
            end else if (r < 68) begin
               // space or non-printable byte
               do begin
                  c = $urandom_range(0, 255);
               end while (c == tgr_pkg::NEWLINE_CODE ||
                          (c > tgr_pkg::FIRST_CODE && c <= tgr_pkg::LAST_CODE));
               render_char(8'(c));
               counted++;
            end else if (r < 80) begin
               load_glyph(8'($urandom_range(tgr_pkg::FIRST_CODE, tgr_pkg::LAST_CODE)),
                          16'($urandom));
               counted++;
            end else if (r < 90) begin
               move_pen(random_coord(), random_coord());
               counted++;
            end else if (r < 95) begin
               send_command(FUNC_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom));
            end else begin
               do begin
                  c = $urandom_range(0, 255);
               end while (c >= tgr_pkg::FIRST_CODE && c <= tgr_pkg::LAST_CODE);
               load_glyph(8'(c), 16'($urandom));
            end
         end
      end
   endtask

   initial begin
      mismatches    = 0;
      cycle_count   = 0;
      send_quiet    = 0;
      recv_quiet    = 0;
      pen_col       = 0;
      pen_row       = 0;
      margin_col    = 0;
      color_setting = 32'd0;
      scale_setting = 2'd1;
      for (int i = 0; i < tgr_pkg::GLYPH_COUNT; i++) begin
         font_words[i]   = 16'd0;
         font_written[i] = 1'b0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_glyph_loads();
      test_render_basics();
      test_coordinate_saturation();
      test_random_text();

      wait_for_pixels(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("PASS text_glyph_rasterizer");
      end else begin
         $display("FAIL text_glyph_rasterizer");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/tgr_pkg.sv
hw/rtl/text_glyph_rasterizer.sv
tb/sv/tb_text_glyph_rasterizer.sv
